>>> rtl/core/wmm_pkg.sv
`timescale 1ns / 1ps

package wmm_pkg;

  localparam int DEPTH          = 32;
  localparam int SAMPLE_W       = 12;
  localparam int PTR_W          = $clog2(DEPTH);
  localparam int FILL_W         = $clog2(DEPTH + 1);
  localparam int SUM_W          = SAMPLE_W + PTR_W;
  localparam int DIVCNT_W       = $clog2(SUM_W);
  localparam int DEFAULT_WINDOW = 8;
  localparam int DEFAULT_EFF    = (DEFAULT_WINDOW > DEPTH) ? DEPTH : DEFAULT_WINDOW;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [FILL_W-1:0]   fill_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } st_t;

endpackage

>>> rtl/core/wmm_intf.sv
`timescale 1ns / 1ps

interface wmm_in_if import wmm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wmm_out_if import wmm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t window_min;
  sample_t window_max;
  sample_t window_mean;
  sample_t all_time_min;
  sample_t all_time_max;
  fill_t   fill_count;

  modport source (output valid, output window_min, output window_max, output window_mean,
                  output all_time_min, output all_time_max, output fill_count,
                  input ready);
  modport sink   (input valid, input window_min, input window_max, input window_mean,
                  input all_time_min, input all_time_max, input fill_count,
                  output ready);
endinterface

>>> rtl/core/window_min_max_avg_tracker.sv
`timescale 1ns / 1ps

// Sliding-window statistics of 12-bit converter samples. Each word taken on
// feed is written into a 32-entry circular history whose active length is the
// window register (0 selects 8, values above 32 saturate to 32); writing the
// register restarts the fill count and write pointer but keeps the history
// and the all-time extremes. For every sample one word leaves on stats with
// the minimum, maximum and truncated mean of the filled entries, the running
// all-time minimum and maximum, and the fill count. The block handles one
// sample at a time: after an acceptance it runs a serial scan of the history
// memory through its single registered read port and a one-bit-per-cycle
// restoring divider for the mean, then loads the output register once it is
// free and returns to idle with feed ready. A finished word waits in the
// output register, so a new sample is taken while stats is stalled.

module window_min_max_avg_tracker import wmm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [FILL_W-1:0] cfg_wdata,
  wmm_in_if.sink            feed,
  wmm_out_if.source         stats
);

  // History memory, written on acceptance and read back during the scan
  sample_t mem [DEPTH];
  sample_t rd_data;

  st_t state, state_next;

  fill_t             window;
  fill_t             eff_win;
  logic [PTR_W-1:0]  wp;
  fill_t             fill;
  fill_t             rd_idx;
  logic              rd_pend;

  sample_t           lo_acc;
  sample_t           hi_acc;
  logic [SUM_W-1:0]  sum_acc;
  sample_t           lowest;
  sample_t           highest;

  // Divider: remainder on top, dividend shifting out / quotient shifting in
  logic [FILL_W:0]    rem;
  logic [SUM_W-1:0]   quo;
  logic [DIVCNT_W-1:0] div_cnt;
  logic [FILL_W:0]    trial;
  logic               take;

  logic              accept;
  logic              issue;
  logic              out_load;
  logic [FILL_W-1:0] wp_inc;
  logic [PTR_W-1:0]  wr_addr;

  logic    out_valid;
  sample_t out_min;
  sample_t out_max;
  sample_t out_mean;
  sample_t out_amin;
  sample_t out_amax;
  fill_t   out_fill;

  // Effective window: zero selects the default, oversize saturates to depth
  always_comb begin
    if (window == '0) begin
      eff_win = FILL_W'(DEFAULT_EFF);
    end else if (window > FILL_W'(DEPTH)) begin
      eff_win = FILL_W'(DEPTH);
    end else begin
      eff_win = window;
    end
  end

  assign wr_addr = ({1'b0, wp} >= eff_win) ? '0 : wp;
  assign wp_inc  = {1'b0, wr_addr} + FILL_W'(1);
  assign accept  = feed.valid && feed.ready;

  // One restoring-division step
  assign trial = {rem[FILL_W-1:0], quo[SUM_W-1]};
  assign take  = (trial >= {1'b0, fill});

  // Sequencer
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (feed.valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue = (rd_idx != fill);
        // leave once the last read has been folded in
        if (!issue && !rd_pend) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == DIVCNT_W'(SUM_W - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || stats.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window register, write pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= FILL_W'(DEFAULT_WINDOW);
      wp     <= '0;
      fill   <= '0;
    end else if (cfg_we) begin
      window <= cfg_wdata;
      wp     <= '0;
      fill   <= '0;
    end else if (accept) begin
      wp <= (wp_inc >= eff_win) ? '0 : wp_inc[PTR_W-1:0];
      if (fill < eff_win) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_addr] <= feed.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_idx[PTR_W-1:0]];
    end
  end

  // Scan address and read-pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (accept) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + FILL_W'(1);
      end
    end
  end

  // Min, max and sum accumulation
  always_ff @(posedge clk) begin
    if (accept) begin
      lo_acc  <= '1;
      hi_acc  <= '0;
      sum_acc <= '0;
    end else if (rd_pend) begin
      if (rd_data < lo_acc) begin
        lo_acc <= rd_data;
      end
      if (rd_data > hi_acc) begin
        hi_acc <= rd_data;
      end
      sum_acc <= sum_acc + {{PTR_W{1'b0}}, rd_data};
    end
  end

  // All-time extremes, folded in as the scan completes
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest  <= '1;
      highest <= '0;
    end else if (state == ST_SCAN && state_next == ST_DIV) begin
      if (lo_acc < lowest) begin
        lowest <= lo_acc;
      end
      if (hi_acc > highest) begin
        highest <= hi_acc;
      end
    end
  end

  // Serial divider for the mean
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && state_next == ST_DIV) begin
      rem     <= '0;
      quo     <= sum_acc;
      div_cnt <= '0;
    end else if (state == ST_DIV) begin
      rem     <= take ? (trial - {1'b0, fill}) : trial;
      quo     <= {quo[SUM_W-2:0], take};
      div_cnt <= div_cnt + DIVCNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (stats.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min  <= lo_acc;
      out_max  <= hi_acc;
      out_mean <= quo[SAMPLE_W-1:0];
      out_amin <= lowest;
      out_amax <= highest;
      out_fill <= fill;
    end
  end

  assign feed.ready         = (state == ST_IDLE);
  assign stats.valid        = out_valid;
  assign stats.window_min   = out_min;
  assign stats.window_max   = out_max;
  assign stats.window_mean  = out_mean;
  assign stats.all_time_min = out_amin;
  assign stats.all_time_max = out_amax;
  assign stats.fill_count   = out_fill;

  // Fill count and write pointer stay inside the active window
  a_fill_in_window: assert property (@(posedge clk) disable iff (rst)
    (fill <= eff_win) && ({1'b0, wp} < eff_win))
    else $error("fill count or write pointer outside window");

  // A result always covers at least one entry
  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (fill != '0))
    else $error("result with empty window");

  // Mean lies between window minimum and maximum
  a_mean_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_min <= out_mean) && (out_mean <= out_max))
    else $error("window mean outside min/max");

  // All-time extremes enclose the window extremes
  a_all_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_amin <= out_min) && (out_amax >= out_max))
    else $error("all-time extremes do not enclose window");

endmodule
